/* hw/rtl/sac_pkg.sv */
`default_nettype none

package sac_pkg;

  localparam int unsigned MAX_CLUSTERS    = 8;
  localparam int unsigned MAX_DIMS        = 16;
  localparam int unsigned MAX_LAG         = 16;
  localparam int unsigned EXP_TABLE_DEPTH = 1024;

  localparam int unsigned CL_W       = $clog2(MAX_CLUSTERS);
  localparam int unsigned DIM_W      = $clog2(MAX_DIMS);
  localparam int unsigned LAG_W      = $clog2(MAX_LAG);
  localparam int unsigned PAIR_W     = 2 * CL_W;
  localparam int unsigned EXP_ADDR_W = $clog2(EXP_TABLE_DEPTH);
  localparam int unsigned DIST_W     = 40;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned IDX_SHIFT  = 20 + 16 - EXP_ADDR_W;

  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  localparam logic MODE_CENTER = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    CFG_CLUSTER_COUNT = 2'd0,
    CFG_DIM_COUNT     = 2'd1,
    CFG_LAG           = 2'd2,
    CFG_SCALE         = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic              mode;
    logic [2:0]        cluster;
    logic [3:0]        dim;
    logic signed [15:0] value;
    logic              last_dim;
    logic              last_sample;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  pair_index;
    logic [47:0] cooccur_value;
    logic        last;
  } out_item_t;

  typedef logic [15:0] exp_rom_t [EXP_TABLE_DEPTH];

  // Shift-and-subtract quotient, used only while the table is built.
  function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [15:0] exp_neg_q16(input logic [63:0] a);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] e;
    logic [63:0] kk;
    n    = div_u64(a, LN2_Q32);
    r    = a - n * LN2_Q32;
    term = 64'd1 << 32;
    sum  = term;
    for (int k = 1; k < 40; k++) begin
      kk = 64'(k);
      if (term != 64'd0) begin
        term = div_u64((term * r) >> 32, kk);
        if (kk[0]) sum = sum - term;
        else sum = sum + term;
      end
    end
    if (n >= 64'd40) return 16'd0;
    e = ((sum >> n) + (64'd1 << 15)) >> 16;
    return (e > 64'd65535) ? 16'hFFFF : e[15:0];
  endfunction

  function automatic exp_rom_t build_exp_rom();
    exp_rom_t rom;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      rom[i] = exp_neg_q16(64'(i) << (32 + $clog2(16) - EXP_ADDR_W));
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

`default_nettype wire

/* hw/rtl/soft_assignment_cooccurrence.sv */
// Channel   Handshake                 Payload
// item      start / busy              item_i  (mode, cluster, dim, value, flags)
// config    cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
// result    res_strobe_o (one cycle)  res_o   (pair_index, cooccur_value, last)
//
// A center load is written to the vector memory and leaves busy low.
// A sample component within dim_count makes eight center reads through one
// subtract-square unit; a final component adds a weight lookup for every cluster and, once
// the lag is reached, K*K pair updates on the accumulator memory.
// The last sample of a segment then streams K*K results, one per cycle.
// Configuration is taken only while idle and no item transfer is offered.
// Reset clears the control state and the accumulator valid bits; the receiver cannot stall.
`default_nettype none

module soft_assignment_cooccurrence (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire sac_pkg::in_item_t item_i,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [23:0]       cfg_data_i,
  output logic                   res_strobe_o,
  output sac_pkg::out_item_t     res_o
);

  import sac_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE      = 12'h001,
    S_DIST      = 12'h002,
    S_WMUL_HI   = 12'h004,
    S_WMUL_LO   = 12'h008,
    S_WIDX      = 12'h010,
    S_WSTORE    = 12'h020,
    S_PWB       = 12'h040,
    S_PWB_LATCH = 12'h080,
    S_PRD       = 12'h100,
    S_PWR       = 12'h200,
    S_EMIT      = 12'h400,
    S_DRAIN     = 12'h800
  } state_e;

  state_e state_q;

  logic [3:0]  k_cfg_q;
  logic [4:0]  d_cfg_q;
  logic [3:0]  lag_q;
  logic [23:0] scale_q;
  logic [3:0]  k_eff;
  logic [4:0]  d_eff;

  in_item_t    item_q;
  logic        accept;

  logic [CL_W:0]   iss_q;
  logic            v1_q, v2_q;
  logic [CL_W-1:0] c1_q, c2_q;
  logic [32:0]     sq_q;
  logic [DIST_W-1:0] dist_q [MAX_CLUSTERS];
  logic signed [16:0] diff;
  logic signed [33:0] sq_full;
  logic [DIST_W:0]    dist_sum;

  logic [CL_W-1:0] c_q;
  logic [19:0]     mul_op;
  logic [43:0]     mul_res;
  logic [43:0]     ph_q, pl_q;
  logic [63:0]     x_full;
  logic            zero_q;
  logic [15:0]     rom_q;
  logic [15:0]     w_new;
  logic [15:0]     wcur_q [MAX_CLUSTERS];

  logic [LAG_W-1:0] rp_q;
  logic [12:0]      cnt_q;
  logic [LAG_W-1:0] slot;

  logic [CL_W-1:0] a_q, b_q;
  logic [15:0]     wb_q;
  logic [31:0]     prod_q;
  logic [PAIR_W-1:0] pidx_q;
  logic [PAIR_W-1:0] paddr;
  logic [6:0]        paddr_full;
  logic [ACC_W:0]    acc_sum;
  logic [ACC_W-1:0]  acc_old;
  logic [63:0]       pvld_q;
  logic [7:0]        k_sq;
  logic [PAIR_W-1:0] n_last;
  logic [PAIR_W-1:0] p_q;
  logic              ev_q, elast_q;
  logic [PAIR_W-1:0] eidx_q;

  logic              a_we;
  logic [7:0]        a_waddr, a_raddr;
  logic [15:0]       a_wdata, a_rdata;
  logic              p_we;
  logic [PAIR_W-1:0] p_raddr;
  logic [ACC_W-1:0]  p_wdata, p_rdata;

  logic pair_go;
  logic a_last, b_last;

  assign k_eff = (k_cfg_q == 4'd0) ? 4'd1 : (k_cfg_q > 4'd8) ? 4'd8 : k_cfg_q;
  assign d_eff = (d_cfg_q == 5'd0) ? 5'd1 : (d_cfg_q > 5'd16) ? 5'd16 : d_cfg_q;
  assign cfg_ready_o = (state_q == S_IDLE) && !start;
  assign busy = (state_q != S_IDLE);
  assign accept = start && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_cfg_q <= 4'd8;
      d_cfg_q <= 5'd16;
      lag_q   <= 4'd1;
      scale_q <= 24'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CLUSTER_COUNT: k_cfg_q <= cfg_data_i[3:0];
        CFG_DIM_COUNT:     d_cfg_q <= cfg_data_i[4:0];
        CFG_LAG:           lag_q   <= cfg_data_i[3:0];
        CFG_SCALE:         scale_q <= cfg_data_i;
        default:           k_cfg_q <= k_cfg_q;
      endcase
    end
  end

  assign diff    = {item_q.value[15], item_q.value} - {a_rdata[15], a_rdata};
  assign sq_full = diff * diff;
  assign dist_sum = {1'b0, dist_q[c2_q]} + {8'd0, sq_q};

  assign mul_op  = (state_q == S_WMUL_HI) ? dist_q[c_q][39:20] : dist_q[c_q][19:0];
  assign mul_res = {24'd0, mul_op} * {20'd0, scale_q};
  assign x_full  = {ph_q, 20'd0} + {20'd0, pl_q};
  assign w_new   = zero_q ? 16'd0 : rom_q;

  assign slot       = rp_q - lag_q;
  assign paddr_full = 7'(a_q) + 7'(b_q) * 7'(k_eff);
  assign paddr      = paddr_full[PAIR_W-1:0];
  assign acc_old    = pvld_q[pidx_q] ? p_rdata : '0;
  assign acc_sum    = {1'b0, acc_old} + {17'd0, prod_q};
  assign k_sq       = 8'(k_eff) * 8'(k_eff);
  assign n_last     = PAIR_W'(k_sq - 8'd1);
  assign a_last     = ({1'b0, a_q} == k_eff - 4'd1);
  assign b_last     = ({1'b0, b_q} == k_eff - 4'd1);
  assign pair_go    = (cnt_q >= {9'd0, lag_q});

  assign a_we    = (accept && item_i.mode == MODE_CENTER) || (state_q == S_WSTORE);
  assign a_waddr = (state_q == S_WSTORE) ? {1'b1, rp_q, c_q}
                                         : {1'b0, item_i.cluster, item_i.dim};
  assign a_wdata = (state_q == S_WSTORE) ? w_new : item_i.value;
  assign a_raddr = (state_q == S_PWB) ? {1'b1, slot, b_q} : {1'b0, iss_q[CL_W-1:0], item_q.dim};

  assign p_we    = (state_q == S_PWR);
  assign p_raddr = (state_q == S_EMIT) ? p_q : paddr;
  assign p_wdata = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

  sac_ram #(.Width(16), .Depth(256)) u_vec_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  sac_ram #(.Width(ACC_W), .Depth(64)) u_pair_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (pidx_q),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_i;
    sq_q   <= sq_full[32:0];
    c2_q   <= c1_q;
    c1_q   <= iss_q[CL_W-1:0];
    if (state_q == S_WMUL_HI) ph_q <= mul_res;
    if (state_q == S_WMUL_LO) pl_q <= mul_res;
    zero_q <= |x_full[63:IDX_SHIFT+EXP_ADDR_W];
    rom_q  <= EXP_ROM[x_full[IDX_SHIFT+EXP_ADDR_W-1:IDX_SHIFT]];
    if (state_q == S_WSTORE) wcur_q[c_q] <= w_new;
    if (state_q == S_PWB_LATCH) wb_q <= a_rdata;
    prod_q <= {16'd0, wb_q} * {16'd0, wcur_q[a_q]};
    pidx_q <= paddr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      iss_q   <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      c_q     <= '0;
      a_q     <= '0;
      b_q     <= '0;
      rp_q    <= '0;
      cnt_q   <= '0;
      pvld_q  <= '0;
      p_q     <= '0;
      ev_q    <= 1'b0;
      elast_q <= 1'b0;
      eidx_q  <= '0;
      for (int i = 0; i < MAX_CLUSTERS; i++) dist_q[i] <= '0;
    end else begin
      v1_q <= (state_q == S_DIST) && !iss_q[CL_W];
      v2_q <= v1_q;
      ev_q <= 1'b0;
      if (v2_q) begin
        dist_q[c2_q] <= dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
      end
      case (state_q)
        S_IDLE: begin
          iss_q <= '0;
          c_q   <= '0;
          if (accept && item_i.mode == MODE_SAMPLE) begin
            if ({1'b0, item_i.dim} < d_eff) state_q <= S_DIST;
            else if (item_i.last_dim) state_q <= S_WMUL_HI;
          end
        end
        S_DIST: begin
          if (!iss_q[CL_W]) iss_q <= iss_q + 1'b1;
          else if (!v1_q && !v2_q) state_q <= item_q.last_dim ? S_WMUL_HI : S_IDLE;
        end
        S_WMUL_HI: state_q <= S_WMUL_LO;
        S_WMUL_LO: state_q <= S_WIDX;
        S_WIDX:    state_q <= S_WSTORE;
        S_WSTORE: begin
          dist_q[c_q] <= '0;
          c_q <= c_q + 1'b1;
          if (c_q != CL_W'(MAX_CLUSTERS - 1)) begin
            state_q <= S_WMUL_HI;
          end else if (pair_go) begin
            b_q     <= '0;
            state_q <= S_PWB;
          end else begin
            rp_q    <= item_q.last_sample ? '0 : rp_q + 1'b1;
            cnt_q   <= item_q.last_sample ? '0 : cnt_q + {12'd0, cnt_q != 13'h1FFF};
            p_q     <= '0;
            state_q <= item_q.last_sample ? S_EMIT : S_IDLE;
          end
        end
        S_PWB: state_q <= S_PWB_LATCH;
        S_PWB_LATCH: begin
          a_q     <= '0;
          state_q <= S_PRD;
        end
        S_PRD: state_q <= S_PWR;
        S_PWR: begin
          pvld_q[pidx_q] <= 1'b1;
          if (!a_last) begin
            a_q     <= a_q + 1'b1;
            state_q <= S_PRD;
          end else if (!b_last) begin
            b_q     <= b_q + 1'b1;
            state_q <= S_PWB;
          end else begin
            rp_q    <= item_q.last_sample ? '0 : rp_q + 1'b1;
            cnt_q   <= item_q.last_sample ? '0 : cnt_q + {12'd0, cnt_q != 13'h1FFF};
            p_q     <= '0;
            state_q <= item_q.last_sample ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          ev_q    <= 1'b1;
          eidx_q  <= p_q;
          elast_q <= (p_q == n_last);
          p_q     <= p_q + 1'b1;
          if (p_q == n_last) state_q <= S_DRAIN;
        end
        S_DRAIN: begin
          pvld_q  <= '0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_strobe_o        = ev_q;
  assign res_o.pair_index    = eidx_q;
  assign res_o.cooccur_value = pvld_q[eidx_q] ? p_rdata : '0;
  assign res_o.last          = elast_q;

endmodule

`default_nettype wire

/* hw/rtl/sac_ram.sv */
`default_nettype none

module sac_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

/* test/soft_assignment_cooccurrence_checker.sv */
`timescale 1ns / 100ps
`default_nettype none

module soft_assignment_cooccurrence_checker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire sac_pkg::in_item_t  item_i,
  input  wire logic               cfg_valid_i,
  input  wire logic               cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [23:0]        cfg_data_i,
  input  wire logic               res_strobe_o,
  input  wire sac_pkg::out_item_t res_o,
  output int                      fail_count,
  output int                      pending_count,
  output int                      result_count
);

  import sac_pkg::*;

  logic signed [15:0] centers [MAX_CLUSTERS*MAX_DIMS];
  logic [DIST_W-1:0]  dist_acc [MAX_CLUSTERS];
  logic [15:0]        weight_ring [MAX_LAG][MAX_CLUSTERS];
  logic [ACC_W-1:0]   pair_sum [MAX_CLUSTERS*MAX_CLUSTERS];
  logic [15:0]        decay_lut [EXP_TABLE_DEPTH];
  int unsigned        seg_samples;
  int unsigned        ring_slot;
  logic [3:0]         k_reg;
  logic [4:0]         d_reg;
  logic [3:0]         lag_reg;
  logic [23:0]        scale_reg;
  out_item_t          expected_q [$];

  function automatic logic [15:0] decay(input logic [63:0] arg);
    logic [63:0] q, rem, t, s, e;
    q   = arg / LN2_Q32;
    rem = arg - q * LN2_Q32;
    t   = 64'd1 << 32;
    s   = t;
    for (int k = 1; k < 40; k++) begin
      if (t != 64'd0) begin
        t = ((t * rem) >> 32) / 64'(k);
        if (k % 2 == 1) s = s - t;
        else s = s + t;
      end
    end
    if (q >= 64'd40) return 16'd0;
    e = ((s >> q) + (64'd1 << 15)) >> 16;
    return (e > 64'd65535) ? 16'hFFFF : e[15:0];
  endfunction

  function automatic logic [15:0] weight(input logic [DIST_W-1:0] d);
    logic [63:0] x, idx;
    x   = 64'(d) * 64'(scale_reg);
    idx = ((x >> 20) * 64'(EXP_TABLE_DEPTH)) >> 16;
    if (idx >= 64'(EXP_TABLE_DEPTH)) return 16'd0;
    return decay_lut[idx];
  endfunction

  task automatic predict(input in_item_t it);
    int unsigned kc, dc, lc, slot;
    logic [15:0] w [MAX_CLUSTERS];
    logic signed [63:0] diff;
    logic [63:0] s;
    out_item_t r;
    if (it.mode == MODE_CENTER) begin
      centers[it.cluster*MAX_DIMS + it.dim] = it.value;
      return;
    end
    kc = (k_reg < 1) ? 1 : (k_reg > MAX_CLUSTERS) ? MAX_CLUSTERS : k_reg;
    dc = (d_reg < 1) ? 1 : (d_reg > MAX_DIMS) ? MAX_DIMS : d_reg;
    lc = (lag_reg > MAX_LAG - 1) ? MAX_LAG - 1 : lag_reg;
    if (it.dim < dc) begin
      for (int c = 0; c < MAX_CLUSTERS; c++) begin
        diff = 64'(it.value) - 64'(centers[c*MAX_DIMS + it.dim]);
        s = 64'(dist_acc[c]) + 64'(diff * diff);
        dist_acc[c] = (s > 64'hFF_FFFF_FFFF) ? '1 : s[DIST_W-1:0];
      end
    end
    if (!it.last_dim) return;
    for (int c = 0; c < MAX_CLUSTERS; c++) begin
      w[c] = weight(dist_acc[c]);
      dist_acc[c] = '0;
      weight_ring[ring_slot][c] = w[c];
    end
    if (seg_samples >= lc) begin
      slot = (ring_slot + MAX_LAG - lc) % MAX_LAG;
      for (int b = 0; b < kc; b++) begin
        for (int a = 0; a < kc; a++) begin
          s = 64'(pair_sum[a + b*kc]) + 64'(weight_ring[slot][b]) * 64'(w[a]);
          pair_sum[a + b*kc] = (s > 64'hFFFF_FFFF_FFFF) ? '1 : s[ACC_W-1:0];
        end
      end
    end
    ring_slot = (ring_slot + 1) % MAX_LAG;
    if (seg_samples < 8191) seg_samples++;
    if (it.last_sample) begin
      for (int p = 0; p < kc*kc; p++) begin
        r.pair_index    = 6'(p);
        r.cooccur_value = pair_sum[p];
        r.last          = (p + 1 == kc*kc);
        expected_q.push_back(r);
      end
      foreach (pair_sum[i]) pair_sum[i] = '0;
      seg_samples = 0;
      ring_slot = 0;
    end
  endtask

  initial begin
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      decay_lut[i] = decay((64'(i) * 64'd16 << 32) / 64'(EXP_TABLE_DEPTH));
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      foreach (centers[i]) centers[i] = '0;
      foreach (dist_acc[i]) dist_acc[i] = '0;
      foreach (pair_sum[i]) pair_sum[i] = '0;
      seg_samples = 0;
      ring_slot = 0;
      k_reg = 4'd8;
      d_reg = 5'd16;
      lag_reg = 4'd1;
      scale_reg = 24'd65536;
      expected_q.delete();
      fail_count = 0;
      result_count = 0;
      pending_count = 0;
    end else begin
      if (res_strobe_o) begin
        result_count++;
        if (expected_q.size() == 0) begin
          $error("unexpected result transfer: pair_index %0d value %0h",
                 res_o.pair_index, res_o.cooccur_value);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (res_o.pair_index !== want.pair_index) begin
            $error("pair_index: expected %0d, got %0d", want.pair_index, res_o.pair_index);
            fail_count++;
          end
          if (res_o.cooccur_value !== want.cooccur_value) begin
            $error("cooccur_value: expected %0h, got %0h",
                   want.cooccur_value, res_o.cooccur_value);
            fail_count++;
          end
          if (res_o.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, res_o.last);
            fail_count++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_CLUSTER_COUNT: k_reg = cfg_data_i[3:0];
          CFG_DIM_COUNT:     d_reg = cfg_data_i[4:0];
          CFG_LAG:           lag_reg = cfg_data_i[3:0];
          CFG_SCALE:         scale_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (start && !busy) predict(item_i);
      pending_count = expected_q.size();
    end
  end

endmodule

`default_nettype wire

/* test/soft_assignment_cooccurrence_test.sv */
`timescale 1ns / 100ps
`default_nettype none

module soft_assignment_cooccurrence_test;
  import sac_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  in_item_t    item_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [23:0] cfg_data_i;
  logic        res_strobe_o;
  out_item_t   res_o;
  int          fail_count;
  int          pending_count;
  int          result_count;
  int unsigned cycle_count = 0;
  int unsigned sample_items;
  int unsigned segments;
  bit          calm;
  int unsigned k_now;
  int unsigned d_now;
  int unsigned lag_now;
  logic signed [15:0] center_copy [MAX_CLUSTERS*MAX_DIMS];

  soft_assignment_cooccurrence u_top (
    .clk_i, .rst_ni, .start, .busy, .item_i, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .res_strobe_o, .res_o
  );

  soft_assignment_cooccurrence_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .item_i, .cfg_valid_i, .cfg_ready_o,
    .cfg_index_i, .cfg_data_i, .res_strobe_o, .res_o,
    .fail_count, .pending_count, .result_count
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic gap();
    if (!calm && $urandom_range(99) < 13) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic send(input in_item_t it);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    if (it.mode == MODE_SAMPLE) sample_items++;
    if (it.mode == MODE_SAMPLE && it.last_dim && it.last_sample) segments++;
    gap();
  endtask

  task automatic load_center(input int cl, input int dm, input logic signed [15:0] v);
    in_item_t it;
    it.mode        = MODE_CENTER;
    it.cluster     = 3'(cl);
    it.dim         = 4'(dm);
    it.value       = v;
    it.last_dim    = 1'($urandom_range(1));
    it.last_sample = 1'($urandom_range(1));
    center_copy[cl*MAX_DIMS + dm] = v;
    send(it);
  endtask

  task automatic settle();
    start <= 1'b0;
    wait (pending_count == 0);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [23:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [3:0] k, input logic [4:0] d, input logic [3:0] l,
                           input logic [23:0] sc);
    settle();
    write_reg(CFG_CLUSTER_COUNT, 24'(k));
    write_reg(CFG_DIM_COUNT, 24'(d));
    write_reg(CFG_LAG, 24'(l));
    write_reg(CFG_SCALE, sc);
    k_now   = (k < 1) ? 1 : (k > 8) ? 8 : k;
    d_now   = (d < 1) ? 1 : (d > 16) ? 16 : d;
    lag_now = l;
  endtask

  task automatic send_sample(input bit seg_end, input int mode_sel);
    in_item_t it;
    int unsigned near_cl;
    near_cl = $urandom_range(k_now - 1);
    for (int dm = 0; dm < d_now; dm++) begin
      if (d_now < MAX_DIMS && $urandom_range(9) == 0) begin
        it = '{MODE_SAMPLE, 3'($urandom), 4'($urandom_range(MAX_DIMS - 1, d_now)),
               16'($urandom), 1'b0, 1'($urandom_range(1))};
        send(it);
      end
      it.mode    = MODE_SAMPLE;
      it.cluster = 3'($urandom);
      it.dim     = 4'(dm);
      case (mode_sel)
        0: it.value = 16'($urandom);
        1: it.value = (dm % 2 == 0) ? 16'sh8000 : 16'sh7FFF;
        default: it.value = center_copy[near_cl*MAX_DIMS + dm] + 16'($signed(
                   $urandom_range(128)) - 64);
      endcase
      it.last_dim    = (dm == d_now - 1);
      it.last_sample = it.last_dim ? seg_end : 1'($urandom_range(3) == 0);
      send(it);
    end
  endtask

  task automatic send_segment(input int len);
    for (int s = 0; s < len; s++) begin
      send_sample(s == len - 1, ($urandom_range(9) < 2) ? 0 : 2);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    item_i       = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = CFG_CLUSTER_COUNT;
    cfg_data_i   = '0;
    sample_items = 0;
    segments     = 0;
    calm         = 1'b0;
    k_now = 8; d_now = 16; lag_now = 1;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int c = 0; c < MAX_CLUSTERS; c++) begin
      for (int dm = 0; dm < MAX_DIMS; dm++) begin
        load_center(c, dm, (c == 0) ? 16'sh8000 : (c == 7) ? 16'sh7FFF :
                    16'($signed($urandom_range(2047)) - 1024));
      end
    end

    send_segment(2);
    send_sample(1'b0, 1);
    send_sample(1'b1, 0);
    configure(4'd0, 5'd0, 4'd0, 24'd1);
    send_segment(1);
    send_segment(2);
    configure(4'd15, 5'd31, 4'd15, 24'hFFFFFF);
    send_segment(1);
    configure(4'd3, 5'd4, 4'd2, 24'd65536);
    send_segment(2);
    send_segment(3);

    calm = 1'b1;
    configure(4'd2, 5'd3, 4'd1, 24'd200000);
    for (int n = 0; n < 3; n++) send_segment($urandom_range(1, 5));
    calm = 1'b0;

    while (sample_items < 140) begin
      configure(4'($urandom_range(15)), 5'($urandom_range(1, 6)), 4'($urandom_range(4)),
                24'($urandom_range(1, 300000)));
      for (int n = 0; n < 2; n++) begin
        if ($urandom_range(3) == 0) begin
          load_center($urandom_range(7), $urandom_range(15),
                      16'($signed($urandom_range(2047)) - 1024));
        end
        send_segment($urandom_range(1, lag_now + 4));
      end
    end
    configure(4'd8, 5'd16, 4'd1, 24'd65536);
    send_segment(1);

    settle();
    $display("Run covered %0d sample transfers in %0d segments with %0d result transfers,",
             sample_items, segments, result_count);
    $display("across clamped, extreme and random register settings.");
    if (fail_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/sac_pkg.sv
hw/rtl/sac_ram.sv
hw/rtl/soft_assignment_cooccurrence.sv
test/soft_assignment_cooccurrence_checker.sv
test/soft_assignment_cooccurrence_test.sv
